>>> hw/rtl/srsw_pkg.sv
package srsw_pkg;

    localparam int MAX_OUT = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 32;

    typedef logic [$clog2(MAX_OUT + 1)-1:0] emit_cnt_t;

    typedef enum logic [1:0] {
        OP_SUBMIT = 2'd0,
        OP_ACK    = 2'd1,
        OP_TICK   = 2'd2
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TIMEOUT = 1'b0,
        CFG_MAX_LEN = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        KIND_SENT        = 3'd0,
        KIND_RETX        = 3'd1,
        KIND_TOO_LONG    = 3'd2,
        KIND_WIN_FULL    = 3'd3,
        KIND_ACK_TAKEN   = 3'd4,
        KIND_ACK_IGNORED = 3'd5,
        KIND_IDLE        = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t       result_kind;
        logic [7:0]  frame_seq;
        logic [15:0] frame_handle;
        logic [15:0] frame_length;
        logic        window_full;
        logic [7:0]  window_base;
        logic        last;
    } result_t;

endpackage

>>> hw/rtl/srsw_item_if.sv
interface srsw_item_if import srsw_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  ack_number;
    logic [15:0] payload_handle;
    logic [15:0] payload_length;

    modport source (output valid, output opcode, output ack_number,
                    output payload_handle, output payload_length, input ready);
    modport sink   (input valid, input opcode, input ack_number,
                    input payload_handle, input payload_length, output ready);
endinterface

>>> hw/rtl/srsw_result_if.sv
interface srsw_result_if import srsw_pkg::*; ();
    logic        valid;
    logic        ready;
    kind_t       result_kind;
    logic [7:0]  frame_seq;
    logic [15:0] frame_handle;
    logic [15:0] frame_length;
    logic        window_full;
    logic [7:0]  window_base;
    logic        last;

    modport source (output valid, output result_kind, output frame_seq,
                    output frame_handle, output frame_length, output window_full,
                    output window_base, output last, input ready);
    modport sink   (input valid, input result_kind, input frame_seq,
                    input frame_handle, input frame_length, input window_full,
                    input window_base, input last, output ready);
endinterface

>>> hw/rtl/srsw_cfg_if.sv
interface srsw_cfg_if import srsw_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/selective_repeat_sender_window.sv
// Sender window of a selective-repeat ARQ link. Each transaction on item is a submit, an
// acknowledgement, a time tick or an unused opcode (idle result); results come out on
// result, the final one of each item flagged by last. Slot records (sequence, handle,
// length, send time) live in one memory with one write and one read port and a registered
// read; in-use and acknowledged flags are flip-flops cleared by reset. One item is handled
// at a time and item.ready is high only between items. A submit goes to S_EMIT; an ack
// reads its slot in S_ACK_DIV, is checked in S_ACK_CHK and, if taken, slides the base in
// S_SLIDE (at most WINDOW slots); a tick scans one slot per cycle through the memory read
// port in S_SCAN, then S_TFIN. Every item, and the scan, wait while result is stalled. A
// finished result waits in an output register while the next item is taken.
// Configuration writes are taken on any cycle but must only come while the block is idle.
module selective_repeat_sender_window import srsw_pkg::*; #(
    parameter int WINDOW    = 8,
    parameter int SEQ_COUNT = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    srsw_cfg_if.sink       cfg,
    srsw_item_if.sink      item,
    srsw_result_if.source  result
);

    localparam int SEQ_W  = $clog2(SEQ_COUNT);
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int REC_W  = SEQ_W + 64;
    localparam int RECIP  = 65536 / WINDOW;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_EMIT    = 7'b0000010,
        S_ACK_DIV = 7'b0000100,
        S_ACK_CHK = 7'b0001000,
        S_SLIDE   = 7'b0010000,
        S_SCAN    = 7'b0100000,
        S_TFIN    = 7'b1000000
    } state_t;

    function automatic logic [SEQ_W:0] seq_dist(input logic [SEQ_W-1:0] a,
                                                 input logic [SEQ_W-1:0] b);
        logic [SEQ_W:0] d;
        if (b >= a)
        begin
            d = {1'b0, b} - {1'b0, a};
        end
        else
        begin
            d = {1'b0, b} + (SEQ_W + 1)'(SEQ_COUNT) - {1'b0, a};
        end
        return d;
    endfunction

    state_t            state_reg, state_next;
    logic [31:0]       timeout_reg, timeout_next;
    logic [15:0]       max_len_reg, max_len_next;
    logic [SEQ_W-1:0]  base_reg, base_next;
    logic [SEQ_W-1:0]  next_reg, next_next;
    logic [IDX_W-1:0]  base_slot_reg, base_slot_next;
    logic [IDX_W-1:0]  next_slot_reg, next_slot_next;
    logic [31:0]       time_reg, time_next;
    logic [WINDOW-1:0] in_use_reg, in_use_next;
    logic [WINDOW-1:0] acked_reg, acked_next;
    result_t           res_reg, res_next;
    logic [7:0]        ack_seq_reg, ack_seq_next;
    logic [7:0]        ack_q_reg, ack_q_next;
    logic [IDX_W-1:0]  ack_slot_reg, ack_slot_next;
    logic [IDX_W:0]    slide_cnt_reg, slide_cnt_next;
    logic [IDX_W:0]    scan_idx_reg, scan_idx_next;
    logic              eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0]  eval_idx_reg, eval_idx_next;
    emit_cnt_t         found_reg, found_next;
    logic              pend_valid_reg, pend_valid_next;
    result_t           pend_reg, pend_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [REC_W-1:0]  mem_wd;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_ra;
    logic [REC_W-1:0]  mem_rd;

    logic [SEQ_W-1:0]  rd_seq;
    logic [15:0]       rd_handle;
    logic [15:0]       rd_length;
    logic [31:0]       rd_time;

    logic              item_fire;
    logic              cfg_fire;
    logic              out_load;
    logic              out_free;
    result_t           out_src;
    result_t           out_data;

    logic [SEQ_W:0]    out_count;
    logic              full_now;
    logic [SEQ_W-1:0]  next_inc;
    logic [IDX_W-1:0]  next_slot_inc;
    logic [SEQ_W-1:0]  base_inc;
    logic [IDX_W-1:0]  base_slot_inc;
    logic [24:0]       ack_prod;
    logic [15:0]       ack_rem;
    logic [15:0]       ack_rem_fix;
    logic [IDX_W-1:0]  ack_slot_calc;
    logic              ack_in_range;
    logic              ack_ok;
    logic              due;
    logic              scan_stall;
    logic              scan_stop;
    emit_cnt_t         found_after;
    result_t           res_blank;

    assign item_fire = item.valid && item.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign cfg.ready  = 1'b1;
    assign item.ready = (state_reg == S_IDLE);

    assign rd_seq    = mem_rd[REC_W-1 -: SEQ_W];
    assign rd_handle = mem_rd[63:48];
    assign rd_length = mem_rd[47:32];
    assign rd_time   = mem_rd[31:0];

    assign out_count = seq_dist(base_reg, next_reg);
    assign full_now  = 32'(out_count) >= 32'(WINDOW);

    assign next_inc      = (next_reg == SEQ_W'(SEQ_COUNT - 1)) ? '0 : next_reg + 1'b1;
    assign next_slot_inc = ((next_reg == SEQ_W'(SEQ_COUNT - 1))
                            || (next_slot_reg == IDX_W'(WINDOW - 1)))
                           ? '0 : next_slot_reg + 1'b1;
    assign base_inc      = (base_reg == SEQ_W'(SEQ_COUNT - 1)) ? '0 : base_reg + 1'b1;
    assign base_slot_inc = ((base_reg == SEQ_W'(SEQ_COUNT - 1))
                            || (base_slot_reg == IDX_W'(WINDOW - 1)))
                           ? '0 : base_slot_reg + 1'b1;

    // slot of an acknowledgement: reciprocal quotient, then one correction
    assign ack_prod      = 25'(item.ack_number) * 25'(RECIP);
    assign ack_rem       = 16'(ack_seq_reg) - 16'(ack_q_reg) * 16'(WINDOW);
    assign ack_rem_fix   = (ack_rem >= 16'(WINDOW)) ? ack_rem - 16'(WINDOW) : ack_rem;
    assign ack_slot_calc = ack_rem_fix[IDX_W-1:0];
    assign ack_in_range  = {1'b0, ack_seq_reg} < 9'(SEQ_COUNT);
    assign ack_ok = ack_in_range
                    && (seq_dist(base_reg, ack_seq_reg[SEQ_W-1:0]) < out_count)
                    && in_use_reg[ack_slot_reg] && !acked_reg[ack_slot_reg]
                    && (rd_seq == ack_seq_reg[SEQ_W-1:0]);

    assign due = eval_valid_reg && in_use_reg[eval_idx_reg] && !acked_reg[eval_idx_reg]
                 && ((time_reg - rd_time) >= timeout_reg);
    assign scan_stall  = due && pend_valid_reg && !out_free;
    assign found_after = found_reg + emit_cnt_t'(due);
    assign scan_stop   = (scan_idx_reg == (IDX_W + 1)'(WINDOW))
                         || (found_after == emit_cnt_t'(MAX_OUT));

    always_comb
    begin
        res_blank             = '0;
        res_blank.result_kind = KIND_IDLE;
        res_blank.last        = 1'b1;
    end

    always_comb
    begin
        out_data             = out_src;
        out_data.window_full = full_now;
        out_data.window_base = 8'(base_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        timeout_next    = timeout_reg;
        max_len_next    = max_len_reg;
        base_next       = base_reg;
        next_next       = next_reg;
        base_slot_next  = base_slot_reg;
        next_slot_next  = next_slot_reg;
        time_next       = time_reg;
        in_use_next     = in_use_reg;
        acked_next      = acked_reg;
        res_next        = res_reg;
        ack_seq_next    = ack_seq_reg;
        ack_q_next      = ack_q_reg;
        ack_slot_next   = ack_slot_reg;
        slide_cnt_next  = slide_cnt_reg;
        scan_idx_next   = scan_idx_reg;
        eval_valid_next = eval_valid_reg;
        eval_idx_next   = eval_idx_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        mem_we          = 1'b0;
        mem_wa          = next_slot_reg;
        mem_wd          = {next_reg, item.payload_handle, item.payload_length, time_reg};
        mem_re          = 1'b0;
        mem_ra          = ack_slot_calc;
        out_load        = 1'b0;
        out_src         = res_reg;

        if (cfg_fire)
        begin
            unique case (cfg.index)
                CFG_TIMEOUT: timeout_next = cfg.data;
                CFG_MAX_LEN: max_len_next = cfg.data[15:0];
                default:     timeout_next = timeout_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    res_next = res_blank;
                    unique case (item.opcode)
                        OP_SUBMIT:
                        begin
                            state_next = S_EMIT;
                            if (item.payload_length > max_len_reg)
                            begin
                                res_next.result_kind = KIND_TOO_LONG;
                            end
                            else if (full_now)
                            begin
                                res_next.result_kind = KIND_WIN_FULL;
                            end
                            else
                            begin
                                mem_we                     = 1'b1;
                                in_use_next[next_slot_reg] = 1'b1;
                                acked_next[next_slot_reg]  = 1'b0;
                                next_next                  = next_inc;
                                next_slot_next             = next_slot_inc;
                                res_next.result_kind       = KIND_SENT;
                                res_next.frame_seq         = 8'(next_reg);
                                res_next.frame_handle      = item.payload_handle;
                                res_next.frame_length      = item.payload_length;
                            end
                        end
                        OP_ACK:
                        begin
                            ack_seq_next = item.ack_number;
                            ack_q_next   = ack_prod[23:16];
                            state_next   = S_ACK_DIV;
                        end
                        OP_TICK:
                        begin
                            time_next       = time_reg + 32'd1;
                            scan_idx_next   = '0;
                            eval_valid_next = 1'b0;
                            found_next      = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ACK_DIV:
            begin
                mem_re        = 1'b1;
                ack_slot_next = ack_slot_calc;
                state_next    = S_ACK_CHK;
            end
            S_ACK_CHK:
            begin
                res_next = res_blank;
                if (ack_ok)
                begin
                    acked_next[ack_slot_reg] = 1'b1;
                    slide_cnt_next           = '0;
                    state_next               = S_SLIDE;
                end
                else
                begin
                    res_next.result_kind = KIND_ACK_IGNORED;
                    state_next           = S_EMIT;
                end
            end
            S_SLIDE:
            begin
                if ((slide_cnt_reg == (IDX_W + 1)'(WINDOW))
                    || !(in_use_reg[base_slot_reg] && acked_reg[base_slot_reg]))
                begin
                    res_next.result_kind = KIND_ACK_TAKEN;
                    state_next           = S_EMIT;
                end
                else
                begin
                    in_use_next[base_slot_reg] = 1'b0;
                    acked_next[base_slot_reg]  = 1'b0;
                    base_next                  = base_inc;
                    base_slot_next             = base_slot_inc;
                    slide_cnt_next             = slide_cnt_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                out_src      = pend_reg;
                out_src.last = 1'b0;
                mem_wa       = eval_idx_reg;
                mem_wd       = {rd_seq, rd_handle, rd_length, time_reg};
                mem_ra       = scan_idx_reg[IDX_W-1:0];
                if (!scan_stall)
                begin
                    // hold one due frame back until the next one or the end of the scan
                    if (due)
                    begin
                        mem_we                 = 1'b1;
                        out_load               = pend_valid_reg;
                        pend_valid_next        = 1'b1;
                        pend_next              = res_blank;
                        pend_next.result_kind  = KIND_RETX;
                        pend_next.frame_seq    = 8'(rd_seq);
                        pend_next.frame_handle = rd_handle;
                        pend_next.frame_length = rd_length;
                        found_next             = found_after;
                    end
                    if (scan_stop)
                    begin
                        eval_valid_next = 1'b0;
                        state_next      = S_TFIN;
                    end
                    else
                    begin
                        mem_re          = 1'b1;
                        eval_valid_next = 1'b1;
                        eval_idx_next   = scan_idx_reg[IDX_W-1:0];
                        scan_idx_next   = scan_idx_reg + 1'b1;
                    end
                end
            end
            S_TFIN:
            begin
                out_src = pend_valid_reg ? pend_reg : res_blank;
                if (out_free)
                begin
                    out_load        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            timeout_reg    <= 32'd500;
            max_len_reg    <= 16'd1024;
            base_reg       <= '0;
            next_reg       <= '0;
            base_slot_reg  <= '0;
            next_slot_reg  <= '0;
            time_reg       <= '0;
            in_use_reg     <= '0;
            acked_reg      <= '0;
            slide_cnt_reg  <= '0;
            scan_idx_reg   <= '0;
            eval_valid_reg <= 1'b0;
            found_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            timeout_reg    <= timeout_next;
            max_len_reg    <= max_len_next;
            base_reg       <= base_next;
            next_reg       <= next_next;
            base_slot_reg  <= base_slot_next;
            next_slot_reg  <= next_slot_next;
            time_reg       <= time_next;
            in_use_reg     <= in_use_next;
            acked_reg      <= acked_next;
            slide_cnt_reg  <= slide_cnt_next;
            scan_idx_reg   <= scan_idx_next;
            eval_valid_reg <= eval_valid_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        ack_seq_reg  <= ack_seq_next;
        ack_q_reg    <= ack_q_next;
        ack_slot_reg <= ack_slot_next;
        eval_idx_reg <= eval_idx_next;
        pend_reg     <= pend_next;
    end

    srsw_slot_mem #(
        .DEPTH  (WINDOW),
        .DATA_W (REC_W)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_wa),
        .wdata (mem_wd),
        .re    (mem_re),
        .raddr (mem_ra),
        .rdata (mem_rd)
    );

    srsw_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_data (out_data),
        .free      (out_free),
        .result    (result)
    );

    a_acked_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (acked_reg & ~in_use_reg) == '0)
        else $error("acknowledged flag set on a slot not in use");

    a_mem_ports: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_wa != mem_ra))
        else $error("slot memory read and written at the same entry");

    a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == S_SCAN || state_reg == S_TFIN))
        else $error("held retransmission outside a tick");

    a_scan_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (found_reg < emit_cnt_t'(MAX_OUT)))
        else $error("tick scan ran past the retransmission limit");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output register overwritten before the transaction");

endmodule

>>> hw/rtl/srsw_slot_mem.sv
module srsw_slot_mem #(
    parameter int DEPTH  = 8,
    parameter int DATA_W = 68
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] slot_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slot_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= slot_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/srsw_out_reg.sv
module srsw_out_reg import srsw_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  result_t              load_data,
    output logic                 free,
    srsw_result_if.source        result
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;
    result_t data_next;

    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = load_data;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign result.valid        = valid_reg;
    assign result.result_kind  = data_reg.result_kind;
    assign result.frame_seq    = data_reg.frame_seq;
    assign result.frame_handle = data_reg.frame_handle;
    assign result.frame_length = data_reg.frame_length;
    assign result.window_full  = data_reg.window_full;
    assign result.window_base  = data_reg.window_base;
    assign result.last         = data_reg.last;

endmodule

>>> sim/tb_selective_repeat_sender_window.sv
`timescale 1ns / 1ps

module tb_selective_repeat_sender_window;
    import srsw_pkg::*;

    localparam int WINDOW      = 8;
    localparam int SEQ_COUNT   = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = WINDOW + 4;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  op;
        logic [7:0]  ack;
        logic [15:0] handle;
        logic [15:0] len;
        bit          typed;
        result_t     want;
        logic [31:0] timeout;
        logic [15:0] max_len;
    } stim_row_t;

    logic clk;
    logic rst_n;

    srsw_cfg_if    cfg_bus();
    srsw_item_if   item_bus();
    srsw_result_if result_bus();

    selective_repeat_sender_window #(
        .WINDOW    (WINDOW),
        .SEQ_COUNT (SEQ_COUNT)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .item   (item_bus),
        .result (result_bus)
    );

    bit          slot_busy   [WINDOW];
    bit          slot_acked  [WINDOW];
    logic [7:0]  slot_seq_no [WINDOW];
    logic [15:0] slot_handle [WINDOW];
    logic [15:0] slot_len    [WINDOW];
    logic [31:0] slot_stamp  [WINDOW];
    int          win_base   = 0;
    int          win_next   = 0;
    logic [31:0] tick_count = '0;
    logic [31:0] retx_after = 32'd500;
    logic [15:0] len_limit  = 16'd1024;

    result_t   owed_results [$];
    stim_row_t script [$];
    int        mismatches = 0;
    int        idle_pct   = 16;
    int        quiet      = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int seq_gap(input int from, input int to);
        return (SEQ_COUNT + to - from) % SEQ_COUNT;
    endfunction

    function automatic bit window_is_full();
        return seq_gap(win_base, win_next) >= WINDOW;
    endfunction

    task automatic step_sender(input logic [1:0] op, input logic [7:0] ackn,
                               input logic [15:0] h, input logic [15:0] l,
                               output result_t outs[$]);
        result_t     r;
        int          s;
        int          i;
        int          b;
        bit          taken;
        logic [31:0] age;
        outs.delete();
        r = '0;
        if (op == OP_SUBMIT)
        begin
            if (l > len_limit)
                r.result_kind = KIND_TOO_LONG;
            else if (window_is_full())
                r.result_kind = KIND_WIN_FULL;
            else
            begin
                s = win_next;
                i = s % WINDOW;
                slot_seq_no[i] = 8'(s);
                slot_handle[i] = h;
                slot_len[i]    = l;
                slot_busy[i]   = 1'b1;
                slot_acked[i]  = 1'b0;
                slot_stamp[i]  = tick_count;
                win_next = (s + 1) % SEQ_COUNT;
                r.result_kind  = KIND_SENT;
                r.frame_seq    = 8'(s);
                r.frame_handle = h;
                r.frame_length = l;
            end
            outs.push_back(r);
        end
        else if (op == OP_ACK)
        begin
            i = ackn % WINDOW;
            taken = 1'b0;
            if (seq_gap(win_base, int'(ackn)) < seq_gap(win_base, win_next) && slot_busy[i]
                && !slot_acked[i] && slot_seq_no[i] == ackn)
            begin
                slot_acked[i] = 1'b1;
                taken = 1'b1;
                for (int guard = 0; guard < WINDOW; guard++)
                begin
                    b = win_base % WINDOW;
                    if (!(slot_busy[b] && slot_acked[b]))
                        break;
                    slot_busy[b]  = 1'b0;
                    slot_acked[b] = 1'b0;
                    win_base = (win_base + 1) % SEQ_COUNT;
                end
            end
            r.result_kind = taken ? KIND_ACK_TAKEN : KIND_ACK_IGNORED;
            outs.push_back(r);
        end
        else if (op == OP_TICK)
        begin
            tick_count = tick_count + 32'd1;
            for (int k = 0; k < WINDOW && outs.size() < MAX_OUT; k++)
            begin
                age = tick_count - slot_stamp[k];
                if (slot_busy[k] && !slot_acked[k] && age >= retx_after)
                begin
                    slot_stamp[k]  = tick_count;
                    r.result_kind  = KIND_RETX;
                    r.frame_seq    = slot_seq_no[k];
                    r.frame_handle = slot_handle[k];
                    r.frame_length = slot_len[k];
                    outs.push_back(r);
                end
            end
            if (outs.size() == 0)
            begin
                r = '0;
                r.result_kind = KIND_IDLE;
                outs.push_back(r);
            end
        end
        else
        begin
            r.result_kind = KIND_IDLE;
            outs.push_back(r);
        end
        foreach (outs[k])
        begin
            outs[k].window_full = window_is_full();
            outs[k].window_base = 8'(win_base);
            outs[k].last        = (k == outs.size() - 1);
        end
    endtask

    task automatic flag_mismatch(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (owed_results.size() == 0)
                flag_mismatch("result transaction with nothing outstanding");
            else
            begin
                want = owed_results.pop_front();
                compare_field("result_kind", 32'(result_bus.result_kind),
                              32'(want.result_kind));
                compare_field("frame_seq", 32'(result_bus.frame_seq), 32'(want.frame_seq));
                compare_field("frame_handle", 32'(result_bus.frame_handle),
                              32'(want.frame_handle));
                compare_field("frame_length", 32'(result_bus.frame_length),
                              32'(want.frame_length));
                compare_field("window_full", 32'(result_bus.window_full),
                              32'(want.window_full));
                compare_field("window_base", 32'(result_bus.window_base),
                              32'(want.window_base));
                compare_field("last", 32'(result_bus.last), 32'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_bus.valid && item_bus.ready)
            || (result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready))
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT)
            begin
                $display("tb_selective_repeat_sender_window: errors");
                $finish;
            end
        end
    end

    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] ackn,
                             input logic [15:0] h, input logic [15:0] l,
                             input bit typed, input result_t want);
        result_t outs [$];
        if ($urandom_range(0, 99) < idle_pct)
        begin
            item_bus.valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        item_bus.valid          <= 1'b1;
        item_bus.opcode         <= op;
        item_bus.ack_number     <= ackn;
        item_bus.payload_handle <= h;
        item_bus.payload_length <= l;
        do
            @(posedge clk);
        while (!item_bus.ready);
        step_sender(op, ackn, h, l, outs);
        if (typed)
            owed_results.push_back(want);
        else
            foreach (outs[k])
                owed_results.push_back(outs[k]);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        if (idx == CFG_TIMEOUT)
            retx_after = value;
        else
            len_limit = value[15:0];
        @(negedge clk);
    endtask

    // drain the outstanding results before touching the registers
    task automatic set_regs(input logic [31:0] timeout, input logic [15:0] max_len);
        item_bus.valid <= 1'b0;
        while (owed_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        write_reg(CFG_TIMEOUT, timeout);
        write_reg(CFG_MAX_LEN, {16'd0, max_len});
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic random_items(input int count);
        int          done;
        int          roll;
        int          s;
        int          pick [$];
        logic [1:0]  op;
        logic [7:0]  ackn;
        logic [15:0] h;
        logic [15:0] l;
        done = 0;
        while (done < count)
        begin
            roll = $urandom_range(0, 99);
            ackn = 8'($urandom);
            h    = 16'($urandom);
            l    = 16'($urandom);
            if (roll < 38)
            begin
                op = OP_SUBMIT;
                if ($urandom_range(0, 9) != 0)
                    l = 16'($urandom_range(0, len_limit));
            end
            else if (roll < 68)
            begin
                op = OP_ACK;
                pick.delete();
                for (int d = 0; d < seq_gap(win_base, win_next); d++)
                begin
                    s = (win_base + d) % SEQ_COUNT;
                    if (slot_busy[s % WINDOW] && !slot_acked[s % WINDOW])
                        pick.push_back(s);
                end
                if (pick.size() != 0 && $urandom_range(0, 9) != 0)
                    ackn = 8'(pick[$urandom_range(0, pick.size() - 1)]);
                else if ($urandom_range(0, 1) != 0)
                    ackn = 8'($urandom_range(0, SEQ_COUNT - 1));
            end
            else if (roll < 95)
                op = OP_TICK;
            else
                op = OP_UNUSED;
            send_item(op, ackn, h, l, 1'b0, '0);
            if (op != OP_UNUSED)
                done++;
        end
    endtask

    function automatic stim_row_t item_row(input logic [1:0] op, input logic [7:0] ackn,
                                           input logic [15:0] h, input logic [15:0] l);
        stim_row_t r;
        r = '{default: 0};
        r.op     = op;
        r.ack    = ackn;
        r.handle = h;
        r.len    = l;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [1:0] op, input logic [7:0] ackn,
                                            input logic [15:0] h, input logic [15:0] l,
                                            input kind_t kind, input bit full,
                                            input logic [7:0] base);
        stim_row_t r;
        r = item_row(op, ackn, h, l);
        r.typed = 1'b1;
        r.want.result_kind = kind;
        r.want.window_full = full;
        r.want.window_base = base;
        r.want.last        = 1'b1;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [31:0] timeout,
                                          input logic [15:0] max_len);
        stim_row_t r;
        r = '{default: 0};
        r.is_cfg  = 1'b1;
        r.timeout = timeout;
        r.max_len = max_len;
        return r;
    endfunction

    initial
    begin
        stim_row_t row;
        item_bus.valid          = 1'b0;
        item_bus.opcode         = '0;
        item_bus.ack_number     = '0;
        item_bus.payload_handle = '0;
        item_bus.payload_length = '0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.index           = '0;
        cfg_bus.data            = '0;
        rst_n                   = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        script.push_back(typed_row(OP_UNUSED, 8'h00, 16'h0000, 16'h0000, KIND_IDLE,
                                   1'b0, 8'd0));
        script.push_back(typed_row(OP_ACK, 8'hFF, 16'h0000, 16'h0000, KIND_ACK_IGNORED,
                                   1'b0, 8'd0));
        script.push_back(typed_row(OP_TICK, 8'h00, 16'h0000, 16'h0000, KIND_IDLE,
                                   1'b0, 8'd0));
        script.push_back(typed_row(OP_SUBMIT, 8'h00, 16'h0001, 16'hFFFF, KIND_TOO_LONG,
                                   1'b0, 8'd0));
        script.push_back(item_row(OP_SUBMIT, 8'h00, 16'h0000, 16'd0));
        script.push_back(item_row(OP_SUBMIT, 8'h00, 16'hFFFF, 16'd1024));
        script.push_back(item_row(OP_SUBMIT, 8'h00, 16'h1234, 16'd64));
        script.push_back(item_row(OP_SUBMIT, 8'h00, 16'h8001, 16'd1));
        script.push_back(item_row(OP_SUBMIT, 8'h00, 16'h00FF, 16'd512));
        script.push_back(item_row(OP_SUBMIT, 8'h00, 16'hFF00, 16'd1000));
        script.push_back(item_row(OP_SUBMIT, 8'h00, 16'h5555, 16'd7));
        script.push_back(item_row(OP_SUBMIT, 8'h00, 16'hAAAA, 16'd1023));
        // too long wins over a full window
        script.push_back(typed_row(OP_SUBMIT, 8'h00, 16'h0002, 16'd2000, KIND_TOO_LONG,
                                   1'b1, 8'd0));
        script.push_back(typed_row(OP_SUBMIT, 8'h00, 16'h0003, 16'd5, KIND_WIN_FULL,
                                   1'b1, 8'd0));
        script.push_back(item_row(OP_ACK, 8'd3, 16'h0000, 16'h0000));
        script.push_back(item_row(OP_ACK, 8'd3, 16'h0000, 16'h0000));
        script.push_back(item_row(OP_ACK, 8'd8, 16'h0000, 16'h0000));
        script.push_back(item_row(OP_ACK, 8'd0, 16'h0000, 16'h0000));
        script.push_back(item_row(OP_ACK, 8'd1, 16'h0000, 16'h0000));
        script.push_back(item_row(OP_ACK, 8'd2, 16'h0000, 16'h0000));
        script.push_back(cfg_row(32'd0, 16'd1024));
        script.push_back(item_row(OP_TICK, 8'h00, 16'h0000, 16'h0000));
        script.push_back(cfg_row(32'd0, 16'd0));
        script.push_back(item_row(OP_SUBMIT, 8'h00, 16'h0F0F, 16'd0));
        script.push_back(typed_row(OP_SUBMIT, 8'h00, 16'h0004, 16'd1, KIND_TOO_LONG,
                                   1'b0, 8'd4));
        script.push_back(cfg_row(32'hFFFF_FFFF, 16'hFFFF));
        script.push_back(typed_row(OP_TICK, 8'h00, 16'h0000, 16'h0000, KIND_IDLE,
                                   1'b0, 8'd4));
        script.push_back(item_row(OP_SUBMIT, 8'h00, 16'hA5A5, 16'hFFFF));

        foreach (script[n])
        begin
            row = script[n];
            if (row.is_cfg)
                set_regs(row.timeout, row.max_len);
            else
                send_item(row.op, row.ack, row.handle, row.len, row.typed, row.want);
        end

        set_regs(32'd1, 16'hFFFF);
        idle_pct = 16;
        random_items(55);

        set_regs($urandom_range(2, 8), 16'($urandom));
        idle_pct = 0;
        random_items(55);

        set_regs(32'hFFFF_FFFF, 16'd0);
        idle_pct = 16;
        random_items(55);

        set_regs($urandom_range(3, 12), 16'd1024);
        random_items(55);

        item_bus.valid <= 1'b0;
        while (owed_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (mismatches == 0)
            $display("tb_selective_repeat_sender_window: clean");
        else
            $display("tb_selective_repeat_sender_window: errors");
        $finish;
    end

endmodule
